// File: rtl/core/hlpsc_pkg.sv
package hlpsc_pkg;

    localparam int unsigned LEN_W      = 32;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_SIZE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_PARAM_SETS = CFG_IDX_W'(1);

    localparam logic [2:0] LENGTH_SIZE_RESET = 3'd4;
    localparam logic [2:0] LENGTH_SIZE_MIN   = 3'd1;
    localparam logic [2:0] LENGTH_SIZE_MAX   = 3'd4;

    localparam logic [5:0] NAL_VPS = 6'd32;
    localparam logic [5:0] NAL_SPS = 6'd33;
    localparam logic [5:0] NAL_PPS = 6'd34;
    localparam logic [5:0] NAL_AUD = 6'd35;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_FIRST  = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_PAST_END = 2'd2
    } status_t;

    // position inside the results of one command
    localparam logic [2:0] POS_SC0  = 3'd0;
    localparam logic [2:0] POS_SC3  = 3'd3;
    localparam logic [2:0] POS_BYTE = 3'd4;
    localparam logic [2:0] POS_MARK = 3'd5;

    typedef struct packed {
        logic       start_code;
        logic       byte_en;
        logic [7:0] data;
        logic       marker;
        status_t    status;
    } cmd_t;

endpackage

// File: rtl/core/hevc_length_prefix_to_start_code.sv
// channel  direction  handshake                  payload
// s_axis   in         s_axis_tvalid/tready       tdata[7:0] data_byte, tlast sample_end
// m_axis   out        m_axis_tvalid/tready       tdata[7:0] out_byte, tlast last,
//                                                tuser[0] is_marker, tuser[2:1] status
// cfg      in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// one input byte per cycle; results leave one per cycle from a registered output
// a nal start expands to four start-code results, stalling input once the
// four-entry command queue fills; end-of-sample adds one marker result
// reset (aresetn low, synchronous) clears the parser, queue and output valid
// input and output stall independently through the command queue
module hevc_length_prefix_to_start_code (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // data_byte
    input  logic                             s_axis_tlast,  // sample_end
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // out_byte
    output logic [2:0]                       m_axis_tuser,  // is_marker, status[1:0]
    output logic                             m_axis_tlast,  // last
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hlpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hlpsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hlpsc_pkg::*;

    logic push, pop, queue_full, queue_empty;
    cmd_t push_cmd, head;
    logic       out_marker;
    logic [1:0] out_status;

    hlpsc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_end     (s_axis_tlast),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    hlpsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty)
    );

    hlpsc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .empty      (queue_empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_marker (out_marker),
        .out_status (out_status),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = {out_status, out_marker};

endmodule

// File: rtl/core/hlpsc_front.sv
module hlpsc_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hlpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hlpsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         in_byte,
    input  logic                               in_end,
    output logic                               push,
    output hlpsc_pkg::cmd_t                    push_cmd,
    input  logic                               queue_full
);
    import hlpsc_pkg::*;

    logic [2:0]       length_size_reg;
    logic             drop_param_sets_reg;
    phase_t           phase_reg, phase_next;
    logic [1:0]       prefix_count_reg, prefix_count_next;
    logic [LEN_W-1:0] remaining_len_reg, remaining_len_next;
    logic             dropping_reg, dropping_next;

    logic             accept;
    logic [2:0]       eff_size;
    logic [1:0]       pc_inc;
    logic             complete;
    logic [LEN_W-1:0] shifted;
    logic             shifted_nz;
    logic [5:0]       unit_kind;
    logic             drop_now;
    logic             body_done;
    logic             in_body;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign accept    = in_valid && !queue_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_size_reg     <= LENGTH_SIZE_RESET;
            drop_param_sets_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_LENGTH_SIZE) begin
                length_size_reg <= cfg_data[2:0];
            end else if (cfg_index == CFG_DROP_PARAM_SETS) begin
                drop_param_sets_reg <= cfg_data[0];
            end
        end
    end

    always_comb begin
        if (length_size_reg < LENGTH_SIZE_MIN) begin
            eff_size = LENGTH_SIZE_MIN;
        end else if (length_size_reg > LENGTH_SIZE_MAX) begin
            eff_size = LENGTH_SIZE_MAX;
        end else begin
            eff_size = length_size_reg;
        end
    end

    assign pc_inc     = prefix_count_reg + 2'd1;
    assign complete   = (pc_inc == 2'd0) || ({1'b0, pc_inc} >= eff_size);
    assign shifted    = {remaining_len_reg[LEN_W-9:0], in_byte};
    assign shifted_nz = (shifted != '0);
    assign unit_kind  = in_byte[6:1];
    assign in_body    = (phase_reg == PH_FIRST) || (phase_reg == PH_BODY);
    assign body_done  = (remaining_len_reg == LEN_W'(1));

    always_comb begin
        if (phase_reg == PH_FIRST) begin
            drop_now = (unit_kind == NAL_AUD) ||
                       (drop_param_sets_reg &&
                        ((unit_kind == NAL_VPS) || (unit_kind == NAL_SPS) ||
                         (unit_kind == NAL_PPS)));
        end else begin
            drop_now = dropping_reg;
        end
    end

    // next state
    always_comb begin
        phase_next         = phase_reg;
        prefix_count_next  = prefix_count_reg;
        remaining_len_next = remaining_len_reg;
        dropping_next      = dropping_reg;
        unique case (phase_reg) inside
            PH_FIRST, PH_BODY: begin
                remaining_len_next = remaining_len_reg - LEN_W'(1);
                phase_next         = body_done ? PH_PREFIX : PH_BODY;
                dropping_next      = body_done ? 1'b0 : drop_now;
            end
            default: begin
                remaining_len_next = shifted;
                prefix_count_next  = complete ? 2'd0 : pc_inc;
                phase_next         = (complete && shifted_nz) ? PH_FIRST : PH_PREFIX;
            end
        endcase
        if (in_end) begin
            phase_next         = PH_PREFIX;
            prefix_count_next  = 2'd0;
            remaining_len_next = '0;
            dropping_next      = 1'b0;
        end
    end

    // command for the back end
    always_comb begin
        push_cmd.data   = in_byte;
        push_cmd.marker = in_end;
        unique case (phase_reg) inside
            PH_FIRST, PH_BODY: begin
                push_cmd.start_code = (phase_reg == PH_FIRST) && !drop_now;
                push_cmd.byte_en    = !drop_now;
                push_cmd.status     = body_done ? ST_OK : ST_PAST_END;
            end
            default: begin
                push_cmd.start_code = 1'b0;
                push_cmd.byte_en    = 1'b0;
                if (complete) begin
                    push_cmd.status = shifted_nz ? ST_PAST_END : ST_OK;
                end else begin
                    push_cmd.status = ST_TRUNC;
                end
            end
        endcase
    end

    assign push = accept && (in_end || (in_body && !drop_now));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_PREFIX;
            prefix_count_reg  <= 2'd0;
            remaining_len_reg <= '0;
            dropping_reg      <= 1'b0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            prefix_count_reg  <= prefix_count_next;
            remaining_len_reg <= remaining_len_next;
            dropping_reg      <= dropping_next;
        end
    end

endmodule

// File: rtl/core/hlpsc_queue.sv
module hlpsc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  hlpsc_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output hlpsc_pkg::cmd_t head,
    output logic            empty
);
    import hlpsc_pkg::*;

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign full    = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QUEUE_PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/hlpsc_back.sv
module hlpsc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  hlpsc_pkg::cmd_t head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_marker,
    output logic [1:0]      out_status,
    output logic            out_last
);
    import hlpsc_pkg::*;

    logic       mid_reg;
    logic [2:0] pos_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       marker_reg;
    status_t    status_reg;
    logic       last_reg;

    logic [2:0] start_pos, cur_pos, next_pos;
    logic       done;
    logic       load;
    logic [7:0] res_byte;
    logic       res_marker;
    status_t    res_status;

    assign load = !empty && (!valid_reg || out_ready);
    assign pop  = load && done;

    always_comb begin
        if (head.start_code) begin
            start_pos = POS_SC0;
        end else if (head.byte_en) begin
            start_pos = POS_BYTE;
        end else begin
            start_pos = POS_MARK;
        end
    end

    assign cur_pos = mid_reg ? pos_reg : start_pos;

    always_comb begin
        next_pos   = POS_MARK;
        done       = 1'b0;
        res_byte   = SC_ZERO;
        res_marker = 1'b0;
        res_status = ST_OK;
        if (cur_pos < POS_SC3) begin
            next_pos = cur_pos + 3'd1;
        end else if (cur_pos == POS_SC3) begin
            res_byte = SC_ONE;
            if (head.byte_en) begin
                next_pos = POS_BYTE;
            end else if (head.marker) begin
                next_pos = POS_MARK;
            end else begin
                done = 1'b1;
            end
        end else if (cur_pos == POS_BYTE) begin
            res_byte = head.data;
            if (head.marker) begin
                next_pos = POS_MARK;
            end else begin
                done = 1'b1;
            end
        end else begin
            res_marker = 1'b1;
            res_status = head.status;
            done       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg   <= 1'b0;
            pos_reg   <= POS_SC0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                mid_reg   <= !done;
                pos_reg   <= next_pos;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= res_byte;
            marker_reg <= res_marker;
            status_reg <= res_status;
            last_reg   <= done;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_marker = marker_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;

endmodule
